// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Staggered derivative package
// Shared types, register codes and reset values of the staggered-grid
// fourth-order derivative unit.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Sample format: two's complement Q7.24.
  localparam int SAMPLE_W = 32;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLUMN_LENGTH = 2'd0,
    REG_COLUMN_COUNT  = 2'd1,
    REG_AXIS          = 2'd2,
    REG_STAGGER       = 2'd3
  } reg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [10:0] RST_COLUMN_LENGTH = 11'd16;
  localparam logic [12:0] RST_COLUMN_COUNT  = 13'd16;
  localparam logic        RST_AXIS          = 1'b0;
  localparam logic        RST_STAGGER       = 1'b0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [2:0][SAMPLE_W-1:0] slot_words_t;

  // Input and output words.
  typedef struct packed {
    sample_t sample;
    logic    is_real;
  } in_word_t;

  typedef struct packed {
    sample_t derivative;
    logic    end_of_grid;
  } out_word_t;

  // Effective configuration as seen by the control logic.
  typedef struct packed {
    logic [10:0] len;
    logic [12:0] cnt;
    logic        axis;
    logic        stagger;
    logic [11:0] lag;
  } cfg_t;

  // First pipeline stage: everything but the line store read data.
  typedef struct packed {
    slot_words_t win;
    sample_t     cur;
    logic [3:0]  live;
    logic        axis;
    logic [1:0]  rot;
    logic        last;
  } stage1_t;

endpackage

// ===== rtl/core/sfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one word of the given type per handshake.
// ----------------------------------------------------------------------------
interface sfd_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/core/sfd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface sfd_cfg_if ();

  logic                            valid;
  logic                            ready;
  logic [sfd_pkg::CFG_INDEX_W-1:0] index;
  logic [sfd_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);

endinterface

// ===== rtl/core/staggered_fd_derivative_unit.sv =====
// ----------------------------------------------------------------------------
// Staggered-grid derivative unit
// Fourth-order staggered first derivative of a column-major 2D field.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls, set by the column
// slot RAMs with one write and one read port each and the fully pipelined
// arithmetic. A derivative passes the first-stage register and the arithmetic
// stages, the last being the output register, after its releasing word is taken.
// Reset (asynchronous, active low) clears positions, the fast-axis window,
// pipeline valid flags and loads the register defaults; the line store keeps
// its contents and is not swept.
module staggered_fd_derivative_unit #(
  parameter int MAX_COLUMN_LENGTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_cfg_if.sink      cfg_i,
  sfd_stream_if.sink   in_i,
  sfd_stream_if.source out_o
);

  sfd_pkg::cfg_t        cfg;
  logic                 s1_valid;
  logic                 s1_ready;
  sfd_pkg::stage1_t     s1;
  sfd_pkg::slot_words_t rd;

  // Configuration registers.
  sfd_cfg #(
    .MAX_COLUMN_LENGTH(MAX_COLUMN_LENGTH)
  ) u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  // Position tracking, line store and tap gathering.
  sfd_ctrl #(
    .MAX_COLUMN_LENGTH(MAX_COLUMN_LENGTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .s1_ready_i(s1_ready),
    .s1_valid_o(s1_valid),
    .s1_o      (s1),
    .rd_o      (rd)
  );

  // Stencil arithmetic and output register.
  sfd_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s1_valid_i(s1_valid),
    .s1_ready_o(s1_ready),
    .s1_i      (s1),
    .rd_i      (rd),
    .out_o     (out_o)
  );

endmodule

// ===== rtl/core/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data (read first).
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sfd_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four registers and derives the effective sizes and the lag.
// ----------------------------------------------------------------------------
module sfd_cfg #(
  parameter int MAX_COLUMN_LENGTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfd_cfg_if.sink       cfg_i,
  output sfd_pkg::cfg_t cfg_o
);

  logic [10:0] column_length_q;
  logic [12:0] column_count_q;
  logic        axis_q;
  logic        stagger_q;
  logic [10:0] len_w;

  // Every write is taken at once.
  assign cfg_i.ready = 1'b1;

  // Register write decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_length_q <= sfd_pkg::RST_COLUMN_LENGTH;
      column_count_q  <= sfd_pkg::RST_COLUMN_COUNT;
      axis_q          <= sfd_pkg::RST_AXIS;
      stagger_q       <= sfd_pkg::RST_STAGGER;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sfd_pkg::REG_COLUMN_LENGTH: column_length_q <= cfg_i.wdata[10:0];
        sfd_pkg::REG_COLUMN_COUNT:  column_count_q  <= cfg_i.wdata[12:0];
        sfd_pkg::REG_AXIS:          axis_q          <= cfg_i.wdata[0];
        sfd_pkg::REG_STAGGER:       stagger_q       <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // Column length is held within one sample and the store depth.
  always_comb begin
    if (column_length_q == '0) begin
      len_w = 11'd1;
    end else if (int'(column_length_q) > MAX_COLUMN_LENGTH) begin
      len_w = 11'(MAX_COLUMN_LENGTH);
    end else begin
      len_w = column_length_q;
    end
  end

  // Effective configuration, including the number of words a derivative trails.
  always_comb begin
    cfg_o.len     = len_w;
    cfg_o.cnt     = (column_count_q == '0) ? 13'd1 : column_count_q;
    cfg_o.axis    = axis_q;
    cfg_o.stagger = stagger_q;
    if (axis_q) begin
      cfg_o.lag = stagger_q ? {len_w, 1'b0} : {1'b0, len_w};
    end else begin
      cfg_o.lag = stagger_q ? 12'd2 : 12'd1;
    end
  end

endmodule

// ===== rtl/core/sfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stencil control
// Tracks grid positions, the fast-axis window and the three column slots of
// the line store, and loads the first pipeline stage with the taps.
// ----------------------------------------------------------------------------
module sfd_ctrl #(
  parameter int MAX_COLUMN_LENGTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfd_pkg::cfg_t        cfg_i,
  sfd_stream_if.sink           in_i,
  input  logic                 s1_ready_i,
  output logic                 s1_valid_o,
  output sfd_pkg::stage1_t     s1_o,
  output sfd_pkg::slot_words_t rd_o
);

  localparam int RowW   = $clog2(MAX_COLUMN_LENGTH);
  localparam int LenMax = (MAX_COLUMN_LENGTH < 2047) ? MAX_COLUMN_LENGTH : 2047;
  localparam int PendW  = $clog2(2 * LenMax + 2);

  logic [RowW-1:0]      in_row_q, in_row_d, out_row_q, out_row_d;
  logic [12:0]          in_col_q, in_col_d, out_col_q, out_col_d;
  logic [1:0]           in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [PendW-1:0]     pend_q, pend_d, pend_inc;
  sfd_pkg::slot_words_t fw_q, fw_d;
  logic                 s1_valid_q;
  sfd_pkg::stage1_t     s1_q, s1_d;

  logic                 accept;
  logic                 is_real;
  sfd_pkg::sample_t     raw;
  logic                 emit;
  logic                 in_row_last, out_row_last, in_col_last, out_col_last;
  logic [2:0]           rot_sum;

  // Handshake: a word is taken whenever the first stage is free or moving on.
  assign in_i.ready = !s1_valid_q || s1_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_real    = in_i.data.is_real;
  assign raw        = is_real ? in_i.data.sample : '0;

  // A derivative is released once enough words trail the output point.
  assign pend_inc = pend_q + PendW'(is_real);
  assign emit     = is_real ? (int'(pend_inc) > int'(cfg_i.lag)) : (pend_q != '0);

  assign in_row_last  = (int'(in_row_q) + 1) >= int'(cfg_i.len);
  assign out_row_last = (int'(out_row_q) + 1) >= int'(cfg_i.len);
  assign in_col_last  = (int'(in_col_q) + 1) >= int'(cfg_i.cnt);
  assign out_col_last = (int'(out_col_q) + 1) >= int'(cfg_i.cnt);

  // Next position, slot and window state.
  always_comb begin
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_slot_d = out_slot_q;
    pend_d     = pend_q;
    fw_d       = fw_q;
    if (accept) begin
      pend_d = pend_inc - PendW'(emit);
      fw_d   = {fw_q[1], fw_q[0], raw};
      if (emit) begin
        if (out_row_last) begin
          out_row_d  = '0;
          out_slot_d = (out_slot_q == 2'd2) ? 2'd0 : out_slot_q + 2'd1;
          out_col_d  = out_col_last ? 13'd0 : out_col_q + 13'd1;
        end else begin
          out_row_d = out_row_q + RowW'(1);
        end
      end
      if (is_real) begin
        if (in_row_last) begin
          in_row_d  = '0;
          in_slot_d = (in_slot_q == 2'd2) ? 2'd0 : in_slot_q + 2'd1;
          in_col_d  = in_col_last ? 13'd0 : in_col_q + 13'd1;
        end else begin
          in_row_d = in_row_q + RowW'(1);
        end
      end
    end
  end

  // Tap set for the first stage: window, boundary mask and slot rotation.
  always_comb begin
    int pos;
    int lim;
    s1_d.win  = fw_q;
    s1_d.cur  = raw;
    s1_d.axis = cfg_i.axis;
    s1_d.last = out_row_last && out_col_last;
    lim = cfg_i.axis ? int'(cfg_i.cnt) : int'(cfg_i.len);
    for (int j = 0; j < 4; j++) begin
      pos = (cfg_i.axis ? int'(out_col_q) : int'(out_row_q)) + int'(cfg_i.stagger) - 2 + j;
      s1_d.live[j] = (pos >= 0) && (pos < lim);
    end
    // The oldest tap lives in slot out_slot + stagger - 2, taken modulo three.
    rot_sum = {1'b0, out_slot_q} + {2'b0, cfg_i.stagger} + 3'd1;
    s1_d.rot = (rot_sum >= 3'd3) ? 2'(rot_sum - 3'd3) : rot_sum[1:0];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      pend_q     <= '0;
      fw_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_slot_q <= out_slot_d;
      pend_q     <= pend_d;
      fw_q       <= fw_d;
      if (in_i.ready) begin
        s1_valid_q <= accept && emit;
      end
    end
  end

  // First-stage payload.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_q <= s1_d;
    end
  end

  // Line store: one RAM per column slot, all read at the output row.
  for (genvar k = 0; k < 3; k++) begin : g_slot
    sfd_ram #(
      .WIDTH(sfd_pkg::SAMPLE_W),
      .DEPTH(MAX_COLUMN_LENGTH)
    ) u_slot (
      .clk_i  (clk_i),
      .we_i   (accept && is_real && (in_slot_q == 2'(k))),
      .waddr_i(in_row_q),
      .wdata_i(raw),
      .re_i   (accept),
      .raddr_i(out_row_q),
      .rdata_o(rd_o[k])
    );
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

// ===== rtl/core/sfd_arith.sv =====
// ----------------------------------------------------------------------------
// Stencil arithmetic
// Computes 27*A - B, rounds by a division by 24 and saturates, over four
// registered stages ending in the output register.
// ----------------------------------------------------------------------------
module sfd_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s1_valid_i,
  output logic                 s1_ready_o,
  input  sfd_pkg::stage1_t     s1_i,
  input  sfd_pkg::slot_words_t rd_i,
  sfd_stream_if.source         out_o
);

  // Clamp window for floor(m/3) to stay inside one sample, and its offset.
  localparam logic signed [35:0] M_HI  = 36'sd6442450943;
  localparam logic signed [35:0] M_LO  = -36'sd6442450944;
  localparam logic signed [35:0] M_OFS = 36'sd6442450944;
  // Reciprocals of three for a 17-bit and a 19-bit dividend.
  localparam logic [17:0] DIV3_HI = 18'd174763;
  localparam logic [19:0] DIV3_LO = 20'd699051;

  logic                va_q, vb_q, vc_q, vd_q;
  logic                rdy_a, rdy_b, rdy_c, rdy_d;
  logic signed [32:0]  a_q, b_q;
  logic signed [35:0]  m_q;
  logic [14:0]         qh_q;
  logic [1:0]          rh_q;
  logic [16:0]         ul_q;
  logic                last_a_q, last_b_q, last_c_q;
  sfd_pkg::out_word_t  out_q;

  sfd_pkg::sample_t    x0, x1, x2, x3;
  logic signed [32:0]  a_d, b_d;
  logic signed [38:0]  a_w, n_w;
  logic signed [35:0]  m_d, mc_w, u_w;
  logic [16:0]         uh_w, r_w;
  logic [34:0]         prod_hi;
  logic [38:0]         prod_lo;
  logic [14:0]         qh_d;
  logic [16:0]         ql_w;
  logic [31:0]         f_w;

  // Stage handshakes: each stage loads when empty or when the next one moves.
  assign rdy_d      = !vd_q || out_o.ready;
  assign rdy_c      = !vc_q || rdy_d;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign s1_ready_o = rdy_a;

  // Tap selection and boundary zeroing, then the two differences.
  always_comb begin
    case (s1_i.rot)
      2'd1: begin
        x0 = rd_i[1];
        x1 = rd_i[2];
        x2 = rd_i[0];
      end
      2'd2: begin
        x0 = rd_i[2];
        x1 = rd_i[0];
        x2 = rd_i[1];
      end
      default: begin
        x0 = rd_i[0];
        x1 = rd_i[1];
        x2 = rd_i[2];
      end
    endcase
    if (!s1_i.axis) begin
      x0 = s1_i.win[2];
      x1 = s1_i.win[1];
      x2 = s1_i.win[0];
    end
    x3 = s1_i.cur;
    if (!s1_i.live[0]) x0 = '0;
    if (!s1_i.live[1]) x1 = '0;
    if (!s1_i.live[2]) x2 = '0;
    if (!s1_i.live[3]) x3 = '0;
    a_d = 33'(x2) - 33'(x1);
    b_d = 33'(x3) - 33'(x0);
  end

  // 27*A - B plus the rounding bias, then the first factor of 24 as a shift.
  always_comb begin
    a_w = 39'(a_q);
    n_w = (a_w <<< 4) + (a_w <<< 3) + (a_w <<< 1) + a_w - 39'(b_q) + 39'sd12;
    m_d = n_w[38:3];
  end

  // Saturation by clamping, offset to unsigned, upper half divided by three.
  always_comb begin
    if (m_q > M_HI) begin
      mc_w = M_HI;
    end else if (m_q < M_LO) begin
      mc_w = M_LO;
    end else begin
      mc_w = m_q;
    end
    u_w     = mc_w + M_OFS;
    uh_w    = u_w[33:17];
    prod_hi = 35'(uh_w) * 35'(DIV3_HI);
    qh_d    = prod_hi[33:19];
    r_w     = uh_w - 17'(qh_d) * 17'd3;
  end

  // Lower half divided by three with the carried remainder; undo the offset.
  always_comb begin
    prod_lo = 39'({rh_q, ul_q}) * 39'(DIV3_LO);
    ql_w    = prod_lo[37:21];
    f_w     = {qh_q, ql_w};
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s1_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (rdy_a && s1_valid_i) begin
      a_q      <= a_d;
      b_q      <= b_d;
      last_a_q <= s1_i.last;
    end
    if (rdy_b && va_q) begin
      m_q      <= m_d;
      last_b_q <= last_a_q;
    end
    if (rdy_c && vb_q) begin
      qh_q     <= qh_d;
      rh_q     <= r_w[1:0];
      ul_q     <= u_w[16:0];
      last_c_q <= last_b_q;
    end
    if (rdy_d && vc_q) begin
      out_q.derivative  <= {~f_w[31], f_w[30:0]};
      out_q.end_of_grid <= last_c_q;
    end
  end

  assign out_o.valid = vd_q;
  assign out_o.data  = out_q;

endmodule
